// ===== src/kch_pkg.sv =====
// shared types, codes and constants of the k-mer count histogram
package kch_pkg;

  // configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MODE    = 2'd2;

  // alphabet modes, anything else behaves as codon mode
  localparam logic [1:0] ALPHA_NT = 2'd0;
  localparam logic [1:0] ALPHA_AA = 2'd1;

  // quotient bits removed by the fold, enough for a radix up to 64
  localparam int FOLD_STEPS = 6;

  // widest word span, 64^8 needs 49 bits
  localparam int SPAN_MAX_W = 49;

  typedef enum logic [1:0] {
    REQ_SYMBOL  = 2'd0,
    REQ_READ    = 2'd1,
    REQ_NEW_SEQ = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_COUNTED      = 3'd0,
    ST_INCOMPLETE   = 3'd1,
    ST_OUT_OF_FRAME = 3'd2,
    ST_INVALID      = 3'd3,
    ST_TOO_LARGE    = 3'd4,
    ST_READ         = 3'd5
  } status_e;

  // what the staged result carries in its index and count fields
  typedef enum logic [2:0] {
    RES_ZERO  = 3'd0,
    RES_WORD  = 3'd1,
    RES_COUNT = 3'd2,
    RES_RDX   = 3'd3,
    RES_READ  = 3'd4
  } res_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic     cap;
    logic     clr_we;
    logic     seq_clear;
    logic     sym_advance;
    logic     invalidate;
    logic     rem_load_roll;
    logic     rem_clear;
    logic     reduce_step;
    logic     mul;
    logic     fold_step;
    logic     roll_update;
    logic     rd_word;
    logic     rd_rdx;
    logic     wr_count;
    logic     wr_zero;
    logic     res_load;
    status_e  res_code;
    res_sel_e res_sel;
    logic     out_load;
  } kch_cmd_t;

  // datapath to controller status
  typedef struct packed {
    req_e req;
    logic sym_bad;
    logic roll_lt_span;
    logic rdx_too_large;
    logic step_last;
    logic clr_last;
    logic run_full;
    logic tainted;
    logic out_of_frame;
    logic idx_too_large;
    logic out_free;
  } kch_sts_t;

  // radix to the power k for the given alphabet mode
  function automatic logic [SPAN_MAX_W-1:0] span_of(input logic [1:0] mode,
                                                    input logic [3:0] k);
    logic [5:0]            sh;
    logic [SPAN_MAX_W-1:0] v;
    sh = 6'(k) * 6'd6;
    v  = '0;
    case (mode)
      ALPHA_NT: begin
        v = SPAN_MAX_W'(1) << (6'(k) * 6'd2);
      end
      ALPHA_AA: begin
        case (k)
          4'd0:    v = SPAN_MAX_W'(1);
          4'd1:    v = SPAN_MAX_W'(22);
          4'd2:    v = SPAN_MAX_W'(484);
          4'd3:    v = SPAN_MAX_W'(10648);
          4'd4:    v = SPAN_MAX_W'(234256);
          4'd5:    v = SPAN_MAX_W'(5153632);
          4'd6:    v = SPAN_MAX_W'(113379904);
          4'd7:    v = SPAN_MAX_W'(64'd2494357888);
          4'd8:    v = SPAN_MAX_W'(64'd54875873536);
          default: v = SPAN_MAX_W'(1);
        endcase
      end
      default: begin
        v = SPAN_MAX_W'(1) << sh;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== src/kch_ctrl.sv =====
// sequencing state machine of the k-mer count histogram
module kch_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kch_pkg::kch_sts_t sts_i,
  output kch_pkg::kch_cmd_t cmd_o
);
  import kch_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_DECODE = 11'b000_0000_0100,
    S_REDUCE = 11'b000_0000_1000,
    S_MUL    = 11'b000_0001_0000,
    S_FOLD   = 11'b000_0010_0000,
    S_UPDATE = 11'b000_0100_0000,
    S_CHECK  = 11'b000_1000_0000,
    S_INC    = 11'b001_0000_0000,
    S_RDCLR  = 11'b010_0000_0000,
    S_RESULT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // state register, the table clear runs first after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.res_code = ST_INCOMPLETE;
    cmd_o.res_sel  = RES_ZERO;
    in_ready_o     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.req)
          REQ_SYMBOL: begin
            cmd_o.sym_advance = 1'b1;
            if (sts_i.sym_bad) begin
              cmd_o.invalidate = 1'b1;
              cmd_o.res_load   = 1'b1;
              cmd_o.res_code   = ST_INVALID;
              state_d          = S_RESULT;
            end else if (sts_i.roll_lt_span) begin
              cmd_o.rem_load_roll = 1'b1;
              state_d             = S_MUL;
            end else begin
              cmd_o.rem_clear = 1'b1;
              state_d         = S_REDUCE;
            end
          end
          REQ_READ: begin
            if (sts_i.rdx_too_large) begin
              cmd_o.res_load = 1'b1;
              cmd_o.res_code = ST_TOO_LARGE;
              cmd_o.res_sel  = RES_RDX;
              state_d        = S_RESULT;
            end else begin
              cmd_o.rd_rdx = 1'b1;
              state_d      = S_RDCLR;
            end
          end
          REQ_NEW_SEQ: begin
            cmd_o.seq_clear = 1'b1;
            cmd_o.res_load  = 1'b1;
            state_d         = S_RESULT;
          end
          default: begin
            cmd_o.res_load = 1'b1;
            state_d        = S_RESULT;
          end
        endcase
      end
      S_REDUCE: begin
        cmd_o.reduce_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.roll_update = 1'b1;
        state_d           = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.run_full) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = sts_i.tainted ? ST_INVALID : ST_INCOMPLETE;
          state_d        = S_RESULT;
        end else if (sts_i.out_of_frame) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_OUT_OF_FRAME;
          cmd_o.res_sel  = RES_WORD;
          state_d        = S_RESULT;
        end else if (sts_i.idx_too_large) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = ST_TOO_LARGE;
          cmd_o.res_sel  = RES_WORD;
          state_d        = S_RESULT;
        end else begin
          cmd_o.rd_word = 1'b1;
          state_d       = S_INC;
        end
      end
      S_INC: begin
        cmd_o.wr_count = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = ST_COUNTED;
        cmd_o.res_sel  = RES_COUNT;
        state_d        = S_RESULT;
      end
      S_RDCLR: begin
        cmd_o.wr_zero  = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = ST_READ;
        cmd_o.res_sel  = RES_READ;
        state_d        = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/kch_datapath.sv =====
// word index arithmetic, count table and result registers
module kch_datapath #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MAX_WORD    = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [kch_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kch_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [1:0]                     req_type_i,
  input  logic [5:0]                     symbol_i,
  input  logic                           symbol_invalid_i,
  input  logic [15:0]                    read_index_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [2:0]                     status_o,
  output logic [15:0]                    word_index_o,
  output logic [31:0]                    count_value_o,
  input  kch_pkg::kch_cmd_t              cmd_i,
  output kch_pkg::kch_sts_t              sts_o
);
  import kch_pkg::*;

  localparam int ROLL_W = 6 * MAX_WORD;
  localparam int SPAN_W = ROLL_W + 1;
  localparam int REM_W  = ROLL_W + 7;
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int W1     = (ROLL_W > AW) ? ROLL_W : AW;
  localparam int EXT_W  = ((W1 > 16) ? W1 : 16) + 1;
  localparam int STEP_W = $clog2(ROLL_W);

  // configuration registers
  logic [3:0] wl_q;
  logic [1:0] am_q;
  logic       fm_q;

  // captured item
  req_e        req_q;
  logic [5:0]  sym_q;
  logic        bad_q;
  logic [15:0] rdx_q;

  // sequence state
  logic [ROLL_W-1:0] rolling_q;
  logic [3:0]        run_q;
  logic [1:0]        phase_q;
  logic [1:0]        phase_now_q;
  logic              taint_q;

  // remainder unit
  logic [REM_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;

  // count table
  logic [COUNT_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [AW-1:0]          addr_q;
  logic [COUNT_WIDTH-1:0] rd_q;

  // staged result and output register
  status_e                res_status_q;
  logic [15:0]            res_idx_q;
  logic [COUNT_WIDTH-1:0] res_cnt_q;
  logic                   out_valid_q;
  status_e                status_q;
  logic [15:0]            widx_q;
  logic [31:0]            cnt_q;

  logic [3:0]             k;
  logic [6:0]             base;
  logic [SPAN_W-1:0]      span;
  logic [EXT_W-1:0]       roll_ext;
  logic [EXT_W-1:0]       rdx_ext;
  logic [REM_W-1:0]       red_t;
  logic [REM_W-1:0]       red_next;
  logic [REM_W-1:0]       mul_next;
  logic [REM_W-1:0]       fold_div;
  logic [REM_W-1:0]       fold_next;
  logic [1:0]             km3;
  logic [2:0]             sp_t;
  logic [1:0]             start_phase;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          rd_addr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] inc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= 4'd3;
      am_q <= ALPHA_NT;
      fm_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WORD_LENGTH:   wl_q <= cfg_data_i;
        CFG_ALPHABET_MODE: am_q <= cfg_data_i[1:0];
        CFG_FRAME_MODE:    fm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective word length, radix and span
  always_comb begin
    if (wl_q == 4'd0) begin
      k = 4'd1;
    end else if (wl_q > 4'(MAX_WORD)) begin
      k = 4'(MAX_WORD);
    end else begin
      k = wl_q;
    end
    case (am_q)
      ALPHA_NT: base = 7'd4;
      ALPHA_AA: base = 7'd22;
      default:  base = 7'd64;
    endcase
    span = SPAN_W'(span_of(am_q, k));
  end

  assign roll_ext = EXT_W'(rolling_q);
  assign rdx_ext  = EXT_W'(rdx_q);

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= req_e'(req_type_i);
      sym_q <= symbol_i;
      bad_q <= symbol_invalid_i;
      rdx_q <= read_index_i;
    end
  end

  // reduce step: one dividend bit into the remainder
  assign red_t    = {rem_q[REM_W-2:0], rolling_q[ROLL_W-1]};
  assign red_next = (red_t >= REM_W'(span)) ? red_t - REM_W'(span) : red_t;

  // radix multiply by shifts, then add the new symbol
  always_comb begin
    case (am_q)
      ALPHA_NT: mul_next = (rem_q << 2) + REM_W'(sym_q);
      ALPHA_AA: mul_next = (rem_q << 4) + (rem_q << 2) + (rem_q << 1) + REM_W'(sym_q);
      default:  mul_next = (rem_q << 6) + REM_W'(sym_q);
    endcase
  end

  // fold step: remove one quotient bit
  assign fold_div  = REM_W'(span) << step_q;
  assign fold_next = (rem_q >= fold_div) ? rem_q - fold_div : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rem_load_roll) begin
      rem_q <= REM_W'(rolling_q);
    end else if (cmd_i.rem_clear) begin
      rem_q <= '0;
    end else if (cmd_i.reduce_step) begin
      rem_q <= red_next;
    end else if (cmd_i.mul) begin
      rem_q <= mul_next;
    end else if (cmd_i.fold_step) begin
      rem_q <= fold_next;
    end
  end

  // step counter of the remainder unit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.rem_clear) begin
      step_q <= STEP_W'(ROLL_W - 1);
    end else if (cmd_i.mul) begin
      step_q <= STEP_W'(FOLD_STEPS - 1);
    end else if (cmd_i.reduce_step || cmd_i.fold_step) begin
      step_q <= step_q - STEP_W'(1);
    end
  end

  // rolling index, run length, phase and taint
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rolling_q   <= '0;
      run_q       <= '0;
      phase_q     <= '0;
      phase_now_q <= '0;
      taint_q     <= 1'b0;
    end else begin
      if (cmd_i.seq_clear || cmd_i.invalidate) begin
        rolling_q <= '0;
        run_q     <= '0;
      end else if (cmd_i.reduce_step) begin
        rolling_q <= rolling_q << 1;
      end else if (cmd_i.roll_update) begin
        rolling_q <= rem_q[ROLL_W-1:0];
        run_q     <= (run_q >= k) ? k : run_q + 4'd1;
      end
      if (cmd_i.seq_clear) begin
        phase_q <= '0;
        taint_q <= 1'b0;
      end else begin
        if (cmd_i.sym_advance) begin
          phase_q     <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
          phase_now_q <= phase_q;
        end
        if (cmd_i.invalidate) begin
          taint_q <= 1'b1;
        end
      end
    end
  end

  // phase of the word start
  always_comb begin
    case (k)
      4'd2, 4'd5, 4'd8: km3 = 2'd1;
      4'd3, 4'd6:       km3 = 2'd2;
      default:          km3 = 2'd0;
    endcase
    sp_t        = 3'(phase_now_q) + 3'd3 - 3'(km3);
    start_phase = (sp_t >= 3'd3) ? 2'(sp_t - 3'd3) : sp_t[1:0];
  end

  // count table port control
  assign mem_we  = cmd_i.clr_we || cmd_i.wr_count || cmd_i.wr_zero;
  assign mem_re  = cmd_i.rd_word || cmd_i.rd_rdx;
  assign rd_addr = cmd_i.rd_word ? roll_ext[AW-1:0] : rdx_ext[AW-1:0];
  assign inc     = (rd_q == '1) ? rd_q : rd_q + COUNT_WIDTH'(1);
  assign wdata   = cmd_i.wr_count ? inc : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else if (cmd_i.clr_we) begin
      addr_q <= addr_q + AW'(1);
    end else if (mem_re) begin
      addr_q <= rd_addr;
    end
  end

  // count table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= wdata;
    end
    if (mem_re) begin
      rd_q <= mem[rd_addr];
    end
  end

  // result staging
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_code;
      case (cmd_i.res_sel)
        RES_WORD: begin
          res_idx_q <= roll_ext[15:0];
          res_cnt_q <= '0;
        end
        RES_COUNT: begin
          res_idx_q <= roll_ext[15:0];
          res_cnt_q <= inc;
        end
        RES_RDX: begin
          res_idx_q <= rdx_q;
          res_cnt_q <= '0;
        end
        RES_READ: begin
          res_idx_q <= rdx_q;
          res_cnt_q <= rd_q;
        end
        default: begin
          res_idx_q <= '0;
          res_cnt_q <= '0;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= res_status_q;
      widx_q   <= res_idx_q;
      cnt_q    <= 32'(res_cnt_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign word_index_o  = widx_q;
  assign count_value_o = cnt_q;

  // status to the controller
  always_comb begin
    sts_o.req           = req_q;
    sts_o.sym_bad       = bad_q || ({1'b0, sym_q} >= base);
    sts_o.roll_lt_span  = {1'b0, rolling_q} < span;
    sts_o.rdx_too_large = rdx_ext >= EXT_W'(TABLE_DEPTH);
    sts_o.step_last     = (step_q == '0);
    sts_o.clr_last      = (addr_q == AW'(TABLE_DEPTH - 1));
    sts_o.run_full      = (run_q == k);
    sts_o.tainted       = taint_q;
    sts_o.out_of_frame  = fm_q && (am_q == ALPHA_NT) && (start_phase != 2'd0);
    sts_o.idx_too_large = roll_ext >= EXT_W'(TABLE_DEPTH);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

endmodule

// ===== src/kmer_count_histogram.sv =====
// k-mer count histogram top level: controller, datapath and checks
// Counts overlapping words of k symbols (base 4, 22 or 64) in a count table
// and answers every request with one result. After reset the block first
// clears the count table, one entry per cycle, while in_ready_o stays low;
// configuration writes are taken at any time. A counted symbol passes
// through one multiply by the radix, six fold steps of the shared
// remainder unit that brings the word index back below radix^k, and a
// read-modify-write of the single-port table before it reaches the output
// register. A symbol whose old index is not below the current span (after
// the word length or alphabet changed) adds 6*MAX_WORD reduce steps. One
// transaction is in flight at a time, and the next one is accepted while
// the previous result waits in the output register.
module kmer_count_histogram #(
  parameter int TABLE_DEPTH = 65536,
  parameter int MAX_WORD    = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kch_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kch_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [5:0]                     symbol_i,
  input  logic                           symbol_invalid_i,
  input  logic [15:0]                    read_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [15:0]                    word_index_o,
  output logic [31:0]                    count_value_o
);
  import kch_pkg::*;

  kch_cmd_t cmd;
  kch_sts_t sts;

  // configuration is always taken
  assign cfg_ready_o = 1'b1;

  // controller
  kch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  kch_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_WORD    (MAX_WORD),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .symbol_i         (symbol_i),
    .symbol_invalid_i (symbol_invalid_i),
    .read_index_i     (read_index_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .word_index_o     (word_index_o),
    .count_value_o    (count_value_o),
    .cmd_i            (cmd),
    .sts_o            (sts)
  );

  // one transaction in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  // only counted and read results carry a count
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_COUNTED && status_o != ST_READ) |->
    (count_value_o == '0))
    else $error("nonzero count on a result without a count");

  // a counted word has a count of at least one
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_COUNTED) |-> (count_value_o != '0))
    else $error("counted word reports a zero count");

  // no full window, no index
  a_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_INCOMPLETE || status_o == ST_INVALID)) |->
    (word_index_o == '0))
    else $error("index reported without a full window");

endmodule
